@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of the split limit counter.
// No dependencies; every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SLC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/slc_pkg.sv @@
// Shared types and constants for the split limit counter.
// No dependencies; used by slc_div and split_limit_counter.
`default_nettype none

package slc_pkg;

  localparam int DATA_W      = 32;
  localparam int LANE_FLD_W  = 4;
  localparam int DIV_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int LANES_DEF   = 16;

  localparam logic [DATA_W-1:0] LIMIT_RESET = 32'd10000;
  localparam logic [DIV_W-1:0]  LANES_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LANES = 2'd1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SUB   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_ADD_ROOM,
    ST_ADD_CHK,
    ST_ADD_LOCAL,
    ST_SUB_LOCAL,
    ST_FOLD_CNT,
    ST_FOLD_RES,
    ST_LIM_A,
    ST_LIM_B,
    ST_LIM_CHK,
    ST_GADD,
    ST_GSUB,
    ST_SPARE_A,
    ST_SPARE_B,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RES_ADD,
    ST_HALF,
    ST_RD_REQ,
    ST_RD_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/slc_div.sv @@
// Bit-serial restoring divider: 32-bit dividend by a 5-bit non-zero divisor.
// One quotient bit per cycle; depends on slc_pkg.
`default_nettype none

module slc_div
  import slc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] q_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dvs_r;

  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;
  logic [DIV_W-1:0]  rem_nxt;

  // remainder stays below the divisor, so the trial fits one extra bit
  assign trial   = {rem_r, q_r[DATA_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign ge      = (trial >= {1'b0, dvs_r});
  assign rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(DATA_W - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[DATA_W-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

`default_nettype wire

@@ rtl/core/split_limit_counter.sv @@
// Add, subtract and flush first fetch and load the lane; a local add then checks its room
// and writes the lane, a local subtract writes it, and a flush folds it into the global state.
// Going global, add and subtract fold the lane, then wait on the 32-step bit-serial divider
// or are refused after the fold. A read does one lane memory read and one add per lane.
// One item at a time, the next taken the cycle after the result is loaded, plus any out stall.
// Reset (rst_n, synchronous): counts, reserve and lane valid bits cleared,
// global_limit 10000, online_lanes 16.
`default_nettype none

module split_limit_counter
  import slc_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data,
  // request stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [39:0]          in_tdata,  // [3:0] lane, [35:4] delta, [39:36] zero
  input  wire logic [1:0]           in_tuser,  // [1:0] command
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [DATA_W-1:0]         out_tdata, // [31:0] total
  output logic [0:0]                out_tuser  // [0] success
);

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

  state_t state_r, state_nxt;

  logic [DATA_W-1:0] limit_r;
  logic [DIV_W-1:0]  online_r;

  cmd_t              cmd_r;
  logic [LANE_FLD_W-1:0] lane_r;
  logic [DATA_W-1:0] delta_r;
  logic              ok_r;
  logic [DATA_W-1:0] total_r;

  logic [DATA_W-1:0] g_count_r;
  logic [DATA_W-1:0] g_reserve_r;
  logic [DATA_W-1:0] lcnt_r;
  logic [DATA_W-1:0] lbud_r;
  logic [DATA_W-1:0] tmp_r;
  logic [DATA_W-1:0] share_r;
  logic [LW-1:0]     idx_r;

  logic              out_valid_r;
  logic              out_success_r;
  logic [DATA_W-1:0] out_total_r;

  // lane store
  logic [DATA_W-1:0] cnt_mem [LANES];
  logic [DATA_W-1:0] bud_mem [LANES];
  logic [LANES-1:0]  vld_r;
  logic [DATA_W-1:0] rd_cnt_r;
  logic [DATA_W-1:0] rd_bud_r;
  logic              rd_vld_r;
  logic [LW-1:0]     lane_addr;
  logic [LW-1:0]     rd_addr;
  logic [DATA_W-1:0] eff_cnt;
  logic [DATA_W-1:0] eff_bud;

  logic              mem_we;
  logic [DATA_W-1:0] mem_wcnt;
  logic [DATA_W-1:0] mem_wbud;

  // shared add/subtract unit
  logic [DATA_W-1:0] alu_a;
  logic [DATA_W-1:0] alu_b;
  logic              alu_sub;
  logic [DATA_W:0]   alu_full;
  logic [DATA_W-1:0] alu_res;
  logic              alu_borrow;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              in_xfer;
  logic              out_free;
  logic              lane_ok;
  cmd_t              in_cmd;

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign lane_ok   = (32'(in_tdata[LANE_FLD_W-1:0]) < 32'(LANES));

  assign lane_addr = LW'(lane_r);
  assign rd_addr   = (state_r == ST_RD_REQ) ? idx_r : lane_addr;
  assign eff_cnt   = rd_vld_r ? rd_cnt_r : '0;
  assign eff_bud   = rd_vld_r ? rd_bud_r : '0;

  assign alu_full   = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                              : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_res    = alu_full[DATA_W-1:0];
  assign alu_borrow = alu_sub && alu_full[DATA_W];

  slc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == CMD_READ)  state_nxt = ST_RD_REQ;
          else if (!lane_ok)       state_nxt = ST_DONE;
          else                     state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_LOAD;
      ST_LOAD: begin
        unique case (cmd_r)
          CMD_ADD: state_nxt = ST_ADD_ROOM;
          CMD_SUB: state_nxt = ST_SUB_LOCAL;
          default: state_nxt = ST_FOLD_CNT;
        endcase
      end
      ST_ADD_ROOM:  state_nxt = ST_ADD_CHK;
      ST_ADD_CHK:   state_nxt = alu_borrow ? ST_FOLD_CNT : ST_ADD_LOCAL;
      ST_ADD_LOCAL: state_nxt = ST_DONE;
      ST_SUB_LOCAL: state_nxt = alu_borrow ? ST_FOLD_CNT : ST_DONE;
      ST_FOLD_CNT:  state_nxt = ST_FOLD_RES;
      ST_FOLD_RES: begin
        unique case (cmd_r)
          CMD_ADD: state_nxt = ST_LIM_A;
          CMD_SUB: state_nxt = ST_GSUB;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_LIM_A:     state_nxt = ST_LIM_B;
      ST_LIM_B:     state_nxt = ST_LIM_CHK;
      ST_LIM_CHK:   state_nxt = alu_borrow ? ST_DONE : ST_GADD;
      ST_GADD:      state_nxt = ST_SPARE_A;
      ST_GSUB:      state_nxt = alu_borrow ? ST_DONE : ST_SPARE_A;
      ST_SPARE_A:   state_nxt = ST_SPARE_B;
      ST_SPARE_B:   state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  state_nxt = div_rsp.done ? ST_RES_ADD : ST_DIV_WAIT;
      ST_RES_ADD:   state_nxt = ST_HALF;
      ST_HALF:      state_nxt = ST_DONE;
      ST_RD_REQ:    state_nxt = ST_RD_ADD;
      ST_RD_ADD:    state_nxt = (idx_r == LW'(LANES - 1)) ? ST_DONE : ST_RD_REQ;
      ST_DONE:      state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- unit controls ----------------
  always_comb begin
    alu_a            = '0;
    alu_b            = '0;
    alu_sub          = 1'b0;
    mem_we           = 1'b0;
    mem_wcnt         = '0;
    mem_wbud         = '0;
    div_req.start    = 1'b0;
    div_req.dividend = tmp_r;
    div_req.divisor  = (online_r == '0) ? DIV_W'(1) : online_r;
    unique case (state_r)
      ST_ADD_ROOM: begin
        alu_a = lbud_r; alu_b = lcnt_r; alu_sub = 1'b1;
      end
      ST_ADD_CHK: begin
        alu_a = tmp_r; alu_b = delta_r; alu_sub = 1'b1;
      end
      ST_ADD_LOCAL: begin
        alu_a    = lcnt_r; alu_b = delta_r;
        mem_we   = 1'b1;
        mem_wcnt = alu_res;
        mem_wbud = lbud_r;
      end
      ST_SUB_LOCAL: begin
        alu_a    = lcnt_r; alu_b = delta_r; alu_sub = 1'b1;
        mem_we   = !alu_borrow;
        mem_wcnt = alu_res;
        mem_wbud = lbud_r;
      end
      ST_FOLD_CNT: begin
        alu_a = g_count_r; alu_b = lcnt_r;
      end
      ST_FOLD_RES: begin
        // lane emptied; a rebalance, if one follows, overwrites it later
        alu_a  = g_reserve_r; alu_b = lbud_r; alu_sub = 1'b1;
        mem_we = 1'b1;
      end
      ST_LIM_A, ST_SPARE_A: begin
        alu_a = limit_r; alu_b = g_count_r; alu_sub = 1'b1;
      end
      ST_LIM_B, ST_SPARE_B: begin
        alu_a = tmp_r; alu_b = g_reserve_r; alu_sub = 1'b1;
      end
      ST_LIM_CHK: begin
        alu_a = tmp_r; alu_b = delta_r; alu_sub = 1'b1;
      end
      ST_GADD: begin
        alu_a = g_count_r; alu_b = delta_r;
      end
      ST_GSUB: begin
        alu_a = g_count_r; alu_b = delta_r; alu_sub = 1'b1;
      end
      ST_DIV_START: div_req.start = 1'b1;
      ST_RES_ADD: begin
        alu_a = g_reserve_r; alu_b = share_r;
      end
      ST_HALF: begin
        // half share, capped at the global count
        alu_a    = g_count_r; alu_b = {1'b0, share_r[DATA_W-1:1]}; alu_sub = 1'b1;
        mem_we   = 1'b1;
        mem_wcnt = alu_borrow ? g_count_r : {1'b0, share_r[DATA_W-1:1]};
        mem_wbud = share_r;
      end
      ST_RD_ADD: begin
        alu_a = total_r; alu_b = eff_cnt;
      end
      default: ;
    endcase
  end

  // ---------------- state and control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_RESET;
      online_r    <= LANES_RESET;
      g_count_r   <= '0;
      g_reserve_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LIMIT)      limit_r  <= cfg_data;
        else if (cfg_index == REG_LANES) online_r <= cfg_data[DIV_W-1:0];
      end
      unique case (state_r)
        ST_FOLD_CNT, ST_GADD: g_count_r <= alu_res;
        ST_GSUB:     if (!alu_borrow) g_count_r <= alu_res;
        ST_HALF:     g_count_r <= alu_borrow ? '0 : alu_res;
        ST_FOLD_RES, ST_RES_ADD: g_reserve_r <= alu_res;
        default: ;
      endcase
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready)                out_valid_r <= 1'b0;
    end
  end

  // ---------------- item datapath ----------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_r   <= in_cmd;
          lane_r  <= in_tdata[LANE_FLD_W-1:0];
          delta_r <= in_tdata[LANE_FLD_W +: DATA_W];
          idx_r   <= '0;
          total_r <= (in_cmd == CMD_READ) ? g_count_r : '0;
          ok_r    <= (in_cmd == CMD_READ) || lane_ok || (in_cmd == CMD_FLUSH);
        end
      end
      ST_LOAD: begin
        lcnt_r <= eff_cnt;
        lbud_r <= eff_bud;
      end
      ST_ADD_ROOM, ST_LIM_A, ST_LIM_B, ST_SPARE_A, ST_SPARE_B: tmp_r <= alu_res;
      ST_LIM_CHK, ST_GSUB: if (alu_borrow) ok_r <= 1'b0;
      ST_DIV_WAIT: if (div_rsp.done) share_r <= div_rsp.quotient;
      ST_RD_ADD: begin
        total_r <= alu_res;
        idx_r   <= idx_r + 1'b1;
      end
      default: ;
    endcase
    if (state_r == ST_DONE && out_free) begin
      out_success_r <= ok_r;
      out_total_r   <= total_r;
    end
  end

  // ---------------- lane memory ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[lane_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[lane_addr] <= mem_wcnt;
      bud_mem[lane_addr] <= mem_wbud;
    end
    rd_cnt_r <= cnt_mem[rd_addr];
    rd_bud_r <= bud_mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_total_r;
  assign out_tuser[0] = out_success_r;

endmodule

`default_nettype wire

@@ rtl/core/slc_chk.sv @@
// Port-level checker for the split limit counter, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module slc_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // one item at a time: busy right after a request transfer
  `SLC_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready)

  // only add and subtract can be refused, and they carry a zero total
  `SLC_ASSERT_IMPL(a_refused_zero, out_tvalid && !out_tuser[0], out_tdata == 32'd0)

  `SLC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind split_limit_counter slc_chk u_slc_chk (.*);

`default_nettype wire
